// File: sv/calendar_time_adder_unit_defines.svh
// ---------------------------------------------------------------------------
// calendar time adder assertion macros
// shared concurrent assertion helpers for the calendar time adder
// ---------------------------------------------------------------------------
`ifndef CALENDAR_TIME_ADDER_UNIT_DEFINES_SVH
`define CALENDAR_TIME_ADDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define CTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under reset
`define CTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/cta_pkg.sv
// ---------------------------------------------------------------------------
// calendar time adder package
// sequencer states, calendar constants and month length helpers
// ---------------------------------------------------------------------------
`default_nettype none

package cta_pkg;

  // shared reciprocal divider: a quotient step from the multiplier, then a step to fold back the remainder
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned CNT_W     = 1;
  localparam int unsigned DAYS_W    = 16;

  localparam logic [5:0] SECS_PER_MIN  = 6'd60;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;

  // reciprocals of 15 and 3, scaled by 2^35 and 2^33, exact for 32-bit dividends
  localparam logic [31:0] RECIP_15 = 32'h8888_8889;
  localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_DIV_HR,
    ST_WALK,
    ST_DONE
  } cta_state_t;

  // gregorian leap test for 2000 + yr, yr in 0..255
  function automatic logic is_leap(input logic [7:0] yr);
    logic by4;
    logic century;
    by4     = (yr[1:0] == 2'b00);
    // 2100 and 2200 are centuries that are not multiples of 400
    century = (yr == 8'd100) || (yr == 8'd200);
    return by4 && !century;
  endfunction

  // month length, with codes outside 1..12 counted as 31 days
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic [7:0] yr);
    logic [4:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = is_leap(yr) ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: sv/calendar_time_adder_unit.sv
// ---------------------------------------------------------------------------
// calendar time adder unit
// adds a seconds offset to a date and time, carrying through to the year
// ---------------------------------------------------------------------------
// sequence: shared reciprocal division (a multiply and a fold each for seconds,
//   minutes and hours), then a walk step per month boundary crossed, a step for
//   the days left in the last month if any, and a step to finish before out_valid
// throughput: one word at a time, in_ready only while idle
// reset: synchronous active-low rst_n returns the sequencer to idle
`default_nettype none

`include "calendar_time_adder_unit_defines.svh"

module calendar_time_adder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  in_cur_seconds,
  input  wire logic [5:0]  in_cur_minutes,
  input  wire logic [4:0]  in_cur_hours,
  input  wire logic [4:0]  in_cur_day,
  input  wire logic [3:0]  in_cur_month,
  input  wire logic [7:0]  in_cur_year,
  input  wire logic [31:0] in_offset_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_new_seconds,
  output logic [5:0]       out_new_minutes,
  output logic [4:0]       out_new_hours,
  output logic [4:0]       out_new_day,
  output logic [3:0]       out_new_month,
  output logic [7:0]       out_new_year
);

  import cta_pkg::*;

  cta_state_t state_r, state_nxt;

  logic [32:0]       quo_r,   quo_nxt;
  logic [31:0]       q_r,     q_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [5:0]        min_r,   min_nxt;
  logic [4:0]        hr_r,    hr_nxt;
  logic [5:0]        osec_r,  osec_nxt;
  logic [5:0]        omin_r,  omin_nxt;
  logic [4:0]        ohr_r,   ohr_nxt;
  logic [4:0]        day_r,   day_nxt;
  logic [3:0]        mon_r,   mon_nxt;
  logic [7:0]        yr_r,    yr_nxt;
  logic [DAYS_W-1:0] days_r,  days_nxt;

  // shared divider datapath
  logic [5:0]  divisor;
  logic [31:0] mul_a;
  logic [31:0] mul_k;
  logic [63:0] prod;
  logic [31:0] q_prod;
  logic [5:0]  qd_lo;
  logic [5:0]  rem_fold;
  logic        div_last;

  // month walk datapath
  logic [4:0]        mlen;
  logic [DAYS_W:0]   day_sum;
  logic              leaves;
  logic [DAYS_W-1:0] used;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    q_r    <= q_nxt;
    min_r  <= min_nxt;
    hr_r   <= hr_nxt;
    osec_r <= osec_nxt;
    omin_r <= omin_nxt;
    ohr_r  <= ohr_nxt;
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    yr_r   <= yr_nxt;
    days_r <= days_nxt;
  end

  // reciprocal division: x/60 as (x>>2)/15, x/24 as (x>>3)/3
  always_comb begin
    if (state_r == ST_DIV_HR) begin
      divisor = HOURS_PER_DAY;
      mul_a   = {2'b00, quo_r[32:3]};
      mul_k   = RECIP_3;
    end else begin
      divisor = (state_r == ST_DIV_MIN) ? MINS_PER_HOUR : SECS_PER_MIN;
      mul_a   = {1'b0, quo_r[32:2]};
      mul_k   = RECIP_15;
    end
    prod     = 64'(mul_a) * 64'(mul_k);
    q_prod   = (state_r == ST_DIV_HR) ? {1'b0, prod[63:33]} : {3'b000, prod[63:35]};
    // the remainder is below 64, so six bits of x - q*d give it exactly
    qd_lo    = 6'(q_r[5:0] * divisor);
    rem_fold = quo_r[5:0] - qd_lo;
    div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  end

  // one month of the walk
  always_comb begin
    mlen    = month_days(mon_r, yr_r);
    day_sum = {{(DAYS_W - 4){1'b0}}, day_r} + {1'b0, days_r};
    leaves  = (day_sum > {{(DAYS_W - 4){1'b0}}, mlen});
    used    = (day_r < mlen) ? DAYS_W'(mlen - day_r + 5'd1) : DAYS_W'(1);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    q_nxt     = q_r;
    min_nxt   = min_r;
    hr_nxt    = hr_r;
    osec_nxt  = osec_r;
    omin_nxt  = omin_r;
    ohr_nxt   = ohr_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    yr_nxt    = yr_r;
    days_nxt  = days_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          quo_nxt   = {1'b0, in_offset_seconds} + {27'd0, in_cur_seconds};
          cnt_nxt   = '0;
          min_nxt   = in_cur_minutes;
          hr_nxt    = in_cur_hours;
          day_nxt   = in_cur_day;
          mon_nxt   = in_cur_month;
          yr_nxt    = in_cur_year;
          state_nxt = ST_DIV_SEC;
        end
      end

      ST_DIV_SEC, ST_DIV_MIN, ST_DIV_HR: begin
        if (!div_last) begin
          // quotient from the shared multiplier
          q_nxt   = q_prod;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          // fold back the remainder and carry the quotient on
          cnt_nxt = '0;
          priority case (state_r)
            ST_DIV_SEC: begin
              osec_nxt  = rem_fold;
              quo_nxt   = {1'b0, q_r} + {27'd0, min_r};
              state_nxt = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
              omin_nxt  = rem_fold;
              quo_nxt   = {1'b0, q_r} + {28'd0, hr_r};
              state_nxt = ST_DIV_HR;
            end
            default: begin
              ohr_nxt   = rem_fold[4:0];
              days_nxt  = q_r[DAYS_W-1:0];
              state_nxt = ST_WALK;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (days_r == '0) begin
          state_nxt = ST_DONE;
        end else if (leaves) begin
          days_nxt = days_r - used;
          day_nxt  = 5'd1;
          // december and bogus codes above it roll into january of next year
          if (mon_r >= MONTH_DEC) begin
            mon_nxt = MONTH_JAN;
            yr_nxt  = yr_r + 8'd1;
          end else begin
            mon_nxt = mon_r + 4'd1;
          end
        end else begin
          day_nxt  = day_sum[4:0];
          days_nxt = '0;
        end
      end

      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result word
  assign out_new_seconds = osec_r;
  assign out_new_minutes = omin_r;
  assign out_new_hours   = ohr_r;
  assign out_new_day     = day_r;
  assign out_new_month   = mon_r;
  assign out_new_year    = yr_r;

  // checks
  `CTA_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  `CTA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CTA_ASSERT_IMP(a_time_range, clk, rst_n, out_valid, (out_new_seconds < 6'd60) && (out_new_minutes < 6'd60) && (out_new_hours < 5'd24))
  `CTA_ASSERT_NXT(a_walk_progress, clk, rst_n, (state_r == ST_WALK) && (days_r != '0), days_r < $past(days_r))

endmodule

`default_nettype wire

// File: verif/calendar_time_adder_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// calendar time adder unit testbench
// feeds dates, times and second offsets through the valid/ready input and
// checks every result word against a behavioural calendar walk held here
// ---------------------------------------------------------------------------
module calendar_time_adder_unit_tb;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_WORDS   = 325;
  localparam int DRAIN_CYCLES   = 2000;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int HOLD_AT_WORD   = 30;
  localparam int HOLD_CYCLES    = 2500;
  localparam int IDLE_MAX       = 4;
  localparam int CALM_SPAN      = 40;
  localparam int MAX_PRINTED    = 100;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned YEAR_BASE     = 2000;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_APR     = 4'd4;
  localparam logic [3:0]  MONTH_JUN     = 4'd6;
  localparam logic [3:0]  MONTH_SEP     = 4'd9;
  localparam logic [3:0]  MONTH_NOV     = 4'd11;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;

  typedef struct packed {
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [7:0]  yr;
    logic [31:0] offset;
  } stamp_t;

  typedef struct packed {
    logic [5:0] secs;
    logic [5:0] mins;
    logic [4:0] hrs;
    logic [4:0] day;
    logic [3:0] mon;
    logic [7:0] yr;
  } date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  in_cur_seconds = '0;
  logic [5:0]  in_cur_minutes = '0;
  logic [4:0]  in_cur_hours = '0;
  logic [4:0]  in_cur_day = '0;
  logic [3:0]  in_cur_month = '0;
  logic [7:0]  in_cur_year = '0;
  logic [31:0] in_offset_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_new_seconds;
  logic [5:0]  out_new_minutes;
  logic [4:0]  out_new_hours;
  logic [4:0]  out_new_day;
  logic [3:0]  out_new_month;
  logic [7:0]  out_new_year;

  stamp_t      stamps_to_send[$];
  date_t       expected_dates[$];
  stamp_t      offered;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  logic        hold_active = 1'b0;

  calendar_time_adder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cur_seconds   (in_cur_seconds),
    .in_cur_minutes   (in_cur_minutes),
    .in_cur_hours     (in_cur_hours),
    .in_cur_day       (in_cur_day),
    .in_cur_month     (in_cur_month),
    .in_cur_year      (in_cur_year),
    .in_offset_seconds(in_offset_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_seconds  (out_new_seconds),
    .out_new_minutes  (out_new_minutes),
    .out_new_hours    (out_new_hours),
    .out_new_day      (out_new_day),
    .out_new_month    (out_new_month),
    .out_new_year     (out_new_year)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // gregorian leap rule on the full year
  function automatic bit leap_year(logic [7:0] yr);
    int unsigned y;
    y = YEAR_BASE + yr;
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // codes outside 1..12 count as 31-day months
  function automatic int unsigned month_length(logic [3:0] mon, logic [7:0] yr);
    int unsigned span;
    case (mon)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: span = 30;
      MONTH_FEB: span = leap_year(yr) ? 29 : 28;
      default: span = 31;
    endcase
    return span;
  endfunction

  // carry the offset through the time fields, then walk whole days month by month
  function automatic date_t add_seconds_to_date(stamp_t s);
    longint unsigned total_secs;
    longint unsigned total_mins;
    longint unsigned total_hrs;
    longint unsigned days_left;
    longint unsigned day;
    longint unsigned span;
    longint unsigned used;
    int unsigned     mon;
    int unsigned     yr;
    date_t           r;
    total_secs = s.offset;
    total_secs = total_secs + s.secs;
    total_mins = total_secs / SECS_PER_MIN + s.mins;
    total_hrs  = total_mins / MINS_PER_HOUR + s.hrs;
    days_left  = total_hrs / HOURS_PER_DAY;
    day = s.day;
    mon = s.mon;
    yr  = s.yr;
    while (days_left > 0) begin
      span = month_length(4'(mon), 8'(yr));
      if (day + days_left > span) begin
        // a day on or past the month end leaves it after exactly one day
        used = (day < span) ? span - day + 1 : 1;
        days_left = days_left - used;
        day = 1;
        mon = mon + 1;
        if (mon > MONTH_DEC) begin
          mon = MONTH_JAN;
          yr  = (yr + 1) & 8'hFF;
        end
      end else begin
        day = day + days_left;
        days_left = 0;
      end
    end
    r.secs = 6'(total_secs % SECS_PER_MIN);
    r.mins = 6'(total_mins % MINS_PER_HOUR);
    r.hrs  = 5'(total_hrs % HOURS_PER_DAY);
    r.day  = 5'(day);
    r.mon  = 4'(mon);
    r.yr   = 8'(yr);
    return r;
  endfunction

  function automatic void queue_stamp(int secs, int mins, int hrs, int day, int mon,
                                      int yr, logic [31:0] offset);
    stamp_t s;
    s.secs   = 6'(secs);
    s.mins   = 6'(mins);
    s.hrs    = 5'(hrs);
    s.day    = 5'(day);
    s.mon    = 4'(mon);
    s.yr     = 8'(yr);
    s.offset = offset;
    stamps_to_send.push_back(s);
  endfunction

  task automatic report_mismatch(string what, int unsigned idx, longint unsigned got,
                                 longint unsigned want);
    if (mismatches < MAX_PRINTED)
      $display("result %0d: %s is %0d, expected %0d", idx, what, got, want);
    mismatches++;
  endtask

  // input driver: one word in flight, idle gap counted while the block is ready
  always @(posedge clk) begin : feed_stamps
    logic fire;
    fire = rst_n && in_valid && in_ready;
    if (fire) begin
      expected_dates.push_back(add_seconds_to_date(offered));
      words_sent <= words_sent + 1;
      tx_wait = (((words_sent / CALM_SPAN) % 3) != 0) ? $urandom_range(0, IDLE_MAX) : 0;
    end else if (!in_valid && in_ready && tx_wait > 0) begin
      tx_wait = tx_wait - 1;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || fire) begin
      if (tx_wait == 0 && stamps_to_send.size() != 0) begin
        offered = stamps_to_send.pop_front();
        in_cur_seconds    <= offered.secs;
        in_cur_minutes    <= offered.mins;
        in_cur_hours      <= offered.hrs;
        in_cur_day        <= offered.day;
        in_cur_month      <= offered.mon;
        in_cur_year       <= offered.yr;
        in_offset_seconds <= offered.offset;
        in_valid          <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : check_results
    logic  take;
    date_t got;
    date_t want;
    take = rst_n && out_valid && out_ready;
    if (take) begin
      got = '{out_new_seconds, out_new_minutes, out_new_hours, out_new_day,
              out_new_month, out_new_year};
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected word, day", results_seen, got.day, 0);
      end else begin
        want = expected_dates.pop_front();
        if (got.secs != want.secs) report_mismatch("seconds", results_seen, got.secs, want.secs);
        if (got.mins != want.mins) report_mismatch("minutes", results_seen, got.mins, want.mins);
        if (got.hrs != want.hrs)   report_mismatch("hours", results_seen, got.hrs, want.hrs);
        if (got.day != want.day)   report_mismatch("day", results_seen, got.day, want.day);
        if (got.mon != want.mon)   report_mismatch("month", results_seen, got.mon, want.mon);
        if (got.yr != want.yr)     report_mismatch("year", results_seen, got.yr, want.yr);
      end
      results_seen <= results_seen + 1;
      // stall for the next word is counted once it is on offer
      rx_wait = (((results_seen / CALM_SPAN) % 3) != 1) ? $urandom_range(0, IDLE_MAX) : 0;
    end else if (out_valid && rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= !hold_active && (rx_wait == 0);
  end

  // one long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin : long_receiver_hold
    if (!rst_n) begin
      hold_active <= 1'b0;
    end else if (!hold_used && words_sent == HOLD_AT_WORD) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      hold_active <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      hold_active <= (hold_left != 0);
    end
  end

  // stimulus, reset and end of run
  initial begin
    stamp_t      s;
    int          kind;
    int unsigned total_words;

    // zero offset and the widest offsets
    queue_stamp(0, 0, 0, 1, 1, 0, 32'd0);
    queue_stamp(0, 0, 0, 1, 1, 0, 32'hFFFF_FFFF);
    queue_stamp(63, 63, 31, 31, 15, 255, 32'hFFFF_FFFF);
    // time fields above range feed the carry chain
    queue_stamp(63, 0, 0, 10, 5, 20, 32'd0);
    queue_stamp(0, 63, 31, 10, 5, 20, 32'd0);
    // february across the leap rules
    queue_stamp(59, 59, 23, 28, 2, 0, 32'd1);
    queue_stamp(59, 59, 23, 28, 2, 100, 32'd1);
    queue_stamp(59, 59, 23, 28, 2, 200, 32'd1);
    queue_stamp(0, 0, 12, 28, 2, 4, SECS_PER_DAY);
    queue_stamp(0, 0, 12, 28, 2, 1, SECS_PER_DAY);
    // year end and year wrap
    queue_stamp(59, 59, 23, 31, 12, 255, 32'd1);
    queue_stamp(30, 15, 6, 31, 12, 10, SECS_PER_DAY);
    // month codes outside the calendar
    queue_stamp(0, 0, 0, 15, 0, 7, 20 * SECS_PER_DAY);
    queue_stamp(0, 0, 0, 31, 13, 99, SECS_PER_DAY);
    queue_stamp(5, 5, 5, 5, 15, 42, 32'd0);
    queue_stamp(0, 0, 0, 3, 14, 42, 32'd3600);
    // day zero and days past the month end
    queue_stamp(0, 0, 0, 0, 1, 3, 32'd0);
    queue_stamp(0, 0, 0, 0, 1, 3, 5 * SECS_PER_DAY);
    queue_stamp(0, 0, 0, 0, 2, 3, 40 * SECS_PER_DAY);
    queue_stamp(0, 0, 0, 31, 4, 3, SECS_PER_DAY);
    queue_stamp(0, 0, 0, 31, 4, 3, 32'd0);
    queue_stamp(0, 0, 0, 31, 2, 1, 3 * SECS_PER_DAY);
    // just short of a day, and a full year on
    queue_stamp(0, 0, 0, 1, 6, 50, SECS_PER_DAY - 1);
    queue_stamp(59, 59, 23, 31, 1, 23, 365 * SECS_PER_DAY);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind   = $urandom_range(0, 99);
      s.mon  = 4'($urandom_range(1, 12));
      s.yr   = 8'($urandom);
      s.day  = 5'($urandom_range(1, month_length(s.mon, s.yr)));
      s.hrs  = 5'($urandom_range(0, 23));
      s.mins = 6'($urandom_range(0, 59));
      s.secs = 6'($urandom_range(0, 59));
      if (kind < 40) begin
        s.offset = $urandom_range(0, 200_000);
      end else if (kind < 60) begin
        s.offset = $urandom_range(0, 40_000_000);
      end else if (kind < 72) begin
        // close to the end of a month or a year
        if (kind < 66) s.mon = MONTH_DEC;
        s.day    = 5'(month_length(s.mon, s.yr));
        s.hrs    = 5'(HOURS_PER_DAY - 1);
        s.mins   = 6'(MINS_PER_HOUR - 1);
        s.secs   = 6'($urandom_range(50, 59));
        s.offset = $urandom_range(0, 200);
      end else if (kind < 87) begin
        // any bit pattern the fields can hold
        s.secs   = 6'($urandom);
        s.mins   = 6'($urandom);
        s.hrs    = 5'($urandom);
        s.day    = 5'($urandom);
        s.mon    = 4'($urandom);
        s.yr     = 8'($urandom);
        s.offset = (kind < 80) ? $urandom_range(0, 3_000_000) : $urandom;
      end else begin
        s.offset = $urandom;
      end
      stamps_to_send.push_back(s);
    end
    total_words = stamps_to_send.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent != total_words) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_dates.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Test completed with failures");
    $finish;
  end

endmodule
